// ===== rtl/bsc_pkg.sv =====
package bsc_pkg;

  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 48;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TEMP = 2'd0,
    REG_PA   = 2'd1,
    REG_PB   = 2'd2,
    REG_PC   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [7:0]  t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [7:0]  p3;
    logic [7:0]  p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [7:0]  p7;
    logic [7:0]  p8;
    logic [15:0] p9;
    logic [7:0]  p10;
    logic [7:0]  p11;
  } coeffs_t;

  function automatic logic [63:0] sdiv2(input logic [63:0] x, input int k);
    logic [63:0] mag;
    mag = 64'd0 - x;
    if (x[63]) begin
      sdiv2 = 64'd0 - (mag >> k);
    end else begin
      sdiv2 = x >> k;
    end
  endfunction

  function automatic logic [63:0] sx8(input logic [7:0] v);
    sx8 = {{56{v[7]}}, v};
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] v);
    sx16 = {{48{v[15]}}, v};
  endfunction

endpackage

// ===== rtl/barometric_sensor_compensation.sv =====
// Barometric sensor compensation, integer form.
// Load the four calibration registers through cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high. Register 0 holds the
// temperature coefficients, registers 1 to 3 the pressure coefficients.
// Start a beat by raising start with raw_pressure and raw_temperature;
// busy is always low, so one beat may enter in every cycle.
// Each beat gives one result beat on temperature_centi and
// pressure_centi_pa, marked by done for one cycle. One beat is taken per
// cycle, and the pipeline depth is set by the chain of six dependent
// 64-bit multiplies, each split over two register stages of 32-bit
// partial products.
// Reset clears the coefficients to zero and drops every beat in flight.
// The receiver cannot stall: done is a strobe and results are not held.
module barometric_sensor_compensation import bsc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [23:0]         raw_pressure,
  input  logic [23:0]         raw_temperature,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output logic                done,
  output logic signed [31:0]  temperature_centi,
  output logic [31:0]         pressure_centi_pa
);

  localparam int Lat = 18;
  localparam int RpDepth = 16;

  coeffs_t cf;
  logic [Lat-1:0] vld;
  logic [63:0] rp [RpDepth];
  logic [63:0] tl [5:8];

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cf <= '0;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TEMP: begin
          cf.t1 <= cfg_data[15:0];
          cf.t2 <= cfg_data[31:16];
          cf.t3 <= cfg_data[39:32];
        end
        REG_PA: begin
          cf.p1 <= cfg_data[15:0];
          cf.p2 <= cfg_data[31:16];
          cf.p3 <= cfg_data[39:32];
          cf.p4 <= cfg_data[47:40];
        end
        REG_PB: begin
          cf.p5 <= cfg_data[15:0];
          cf.p6 <= cfg_data[31:16];
          cf.p7 <= cfg_data[39:32];
          cf.p8 <= cfg_data[47:40];
        end
        REG_PC: begin
          cf.p9  <= cfg_data[15:0];
          cf.p10 <= cfg_data[23:16];
          cf.p11 <= cfg_data[31:24];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[Lat-2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    rp[0] <= 64'(raw_pressure);
    for (int i = 1; i < RpDepth; i++) begin
      rp[i] <= rp[i-1];
    end
  end

  // Stage 0: d = rt - 256*t1.
  logic [63:0] d0;
  always_ff @(posedge clk) begin
    d0 <= 64'(raw_temperature) - {40'd0, cf.t1, 8'd0};
  end

  // Multiply M1 (stages 1-2): b = d*d, a = t2*d.
  logic [63:0] m_b, m_a;
  bsc_mul u_m1a (.clk(clk), .a(d0), .b(d0), .p(m_b));
  bsc_mul u_m1b (.clk(clk), .a(d0), .b({48'd0, cf.t2}), .p(m_a));

  // M2 (stages 3-4): c = b*t3.
  logic [63:0] a3, a4, m_c;
  bsc_mul u_m2 (.clk(clk), .a(m_b), .b(sx8(cf.t3)), .p(m_c));
  always_ff @(posedge clk) begin
    a3 <= m_a;
    a4 <= a3;
  end

  // Stage 5: tlin.
  logic [63:0] e5;
  assign e5 = {a4[45:0], 18'd0} + m_c;
  always_ff @(posedge clk) begin
    tl[5] <= sdiv2(e5, 32);
    tl[6] <= tl[5];
    tl[7] <= tl[6];
    tl[8] <= tl[7];
  end

  // M3 (stages 6-7): sq = tlin^2, t25, f = rp^2, p10*tlin.
  logic [63:0] sq7, t25, f7, p10t;
  bsc_mul u_m3a (.clk(clk), .a(tl[5]), .b(tl[5]), .p(sq7));
  bsc_mul u_m3b (.clk(clk), .a(tl[5]), .b(64'd25), .p(t25));
  bsc_mul u_m3c (.clk(clk), .a(rp[5]), .b(rp[5]), .p(f7));
  bsc_mul u_m3d (.clk(clk), .a(tl[5]), .b(sx8(cf.p10)), .p(p10t));

  // Stage 8: register squares and first-level terms.
  logic [63:0] tc8, sq8, s6_8, f8, bq8;
  always_ff @(posedge clk) begin
    tc8 <= sdiv2(t25, 14);
    sq8 <= sq7;
    s6_8 <= sdiv2(sq7, 6);
    f8 <= f7;
    bq8 <= p10t + (sx16(cf.p9) << 16);
  end

  // M4 (stages 9-10): cube0, p7*sq, p3*sq, p6*tlin, (p2-16384)*tlin,
  // b*rp, p11*f.
  logic [63:0] cb0, p7s, p3s, p6t, p2t, brp, p11f;
  bsc_mul u_m4a (.clk(clk), .a(s6_8), .b(tl[8]), .p(cb0));
  bsc_mul u_m4b (.clk(clk), .a(sq8), .b(sx8(cf.p7)), .p(p7s));
  bsc_mul u_m4c (.clk(clk), .a(sq8), .b(sx8(cf.p3)), .p(p3s));
  bsc_mul u_m4d (.clk(clk), .a(tl[8]), .b({48'd0, cf.p6}), .p(p6t));
  bsc_mul u_m4e (.clk(clk), .a(tl[8]), .b(sx16(cf.p2) - 64'd16384), .p(p2t));
  bsc_mul u_m4f (.clk(clk), .a(bq8), .b(rp[8]), .p(brp));
  bsc_mul u_m4g (.clk(clk), .a(f8), .b(sx8(cf.p11)), .p(p11f));
  logic [63:0] tc9, tc10;
  always_ff @(posedge clk) begin
    tc9 <= tc8;
    tc10 <= tc9;
  end

  // Stage 11: partial sums.
  logic [63:0] cube11, ob11, sb11, c11, q11, tc11;
  always_ff @(posedge clk) begin
    cube11 <= sdiv2(cb0, 8);
    ob11 <= {1'b0, cf.p5, 47'd0} + {p7s[59:0], 4'd0} + {p6t[41:0], 22'd0};
    sb11 <= ((sx16(cf.p1) - 64'd16384) << 46) + {p3s[61:0], 2'd0}
            + {p2t[42:0], 21'd0};
    c11 <= sdiv2(brp, 13);
    q11 <= sdiv2(p11f, 16);
    tc11 <= tc10;
  end

  // M5 (stages 12-13): p8*cube, p4*cube, c*rp, q*rp.
  logic [63:0] p8c, p4c, crp, qrp;
  bsc_mul u_m5a (.clk(clk), .a(cube11), .b(sx8(cf.p8)), .p(p8c));
  bsc_mul u_m5b (.clk(clk), .a(cube11), .b(sx8(cf.p4)), .p(p4c));
  bsc_mul u_m5c (.clk(clk), .a(c11), .b(rp[11]), .p(crp));
  bsc_mul u_m5d (.clk(clk), .a(q11), .b(rp[11]), .p(qrp));
  logic [63:0] ob12, ob13, sb12, sb13, tc12, tc13;
  always_ff @(posedge clk) begin
    ob12 <= ob11;
    ob13 <= ob12;
    sb12 <= sb11;
    sb13 <= sb12;
    tc12 <= tc11;
    tc13 <= tc12;
  end

  // Stage 14: close the offset and sensitivity sums.
  logic [63:0] offs14, sens14, e14, c14, tc14;
  always_ff @(posedge clk) begin
    offs14 <= ob13 + sdiv2(p8c, 5);
    sens14 <= sb13 + sdiv2(p4c, 5);
    e14 <= sdiv2(crp, 9);
    c14 <= sdiv2(qrp, 7);
    tc14 <= tc13;
  end

  // Stage 15: scale the sensitivity and gather the other pressure terms.
  logic [63:0] sdv15, part15, tc15;
  always_ff @(posedge clk) begin
    sdv15 <= sdiv2(sens14, 24);
    part15 <= sdiv2(offs14, 2) + e14 + c14;
    tc15 <= tc14;
  end

  // M6 (stages 16-17): scaled sensitivity times rp.
  logic [63:0] arp, part16, part17, tc16, tc17;
  bsc_mul u_m6 (.clk(clk), .a(sdv15), .b(rp[15]), .p(arp));
  always_ff @(posedge clk) begin
    part16 <= part15;
    part17 <= part16;
    tc16 <= tc15;
    tc17 <= tc16;
  end

  // Stage 18: final sum, scaling and saturation.
  logic [63:0] sum, s25, pc;
  always_comb begin
    sum = part17 + arp;
    s25 = {sum[59:0], 4'd0} + {sum[60:0], 3'd0} + sum;
    pc = s25 >> 40;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[Lat-1];
    end
    if (tc17 + 64'h8000_0000 < 64'h1_0000_0000) begin
      temperature_centi <= tc17[31:0];
    end else if (tc17[63]) begin
      temperature_centi <= 32'sh8000_0000;
    end else begin
      temperature_centi <= 32'sh7fff_ffff;
    end
    pressure_centi_pa <= (pc > 64'hffff_ffff) ? 32'hffff_ffff : pc[31:0];
  end

  assert property (@(posedge clk) disable iff (rst) busy == 1'b0)
    else $error("busy raised");
  assert property (@(posedge clk) disable iff (rst) done |-> $past(vld[Lat-1]))
    else $error("done without beat");
  assert property (@(posedge clk) disable iff (rst)
    start |-> ##(Lat+1) done)
    else $error("beat lost");

endmodule

// ===== rtl/bsc_mul.sv =====
module bsc_mul import bsc_pkg::*; (
  input  logic        clk,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [31:0] ll_hi;
  logic [31:0] lh;
  logic [31:0] hl;
  logic [63:0] ll;

  always_ff @(posedge clk) begin
    ll <= 64'(a[31:0]) * 64'(b[31:0]);
    lh <= a[31:0] * b[63:32];
    hl <= a[63:32] * b[31:0];
  end

  assign ll_hi = ll[63:32] + lh + hl;

  always_ff @(posedge clk) begin
    p <= {ll_hi, ll[31:0]};
  end

endmodule

// ===== tb/barometric_checker.sv =====
`timescale 1ns / 1ps

module barometric_checker import bsc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic [23:0]         raw_pressure,
  input  logic [23:0]         raw_temperature,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                done,
  input  logic signed [31:0]  temperature_centi,
  input  logic [31:0]         pressure_centi_pa,
  output int                  fail_count,
  output int                  pending
);

  typedef struct {
    logic signed [31:0] temp;
    logic [31:0]        press;
  } reading_t;

  logic [39:0] temp_reg;
  logic [47:0] pa_reg;
  logic [47:0] pb_reg;
  logic [31:0] pc_reg;
  reading_t    expected_readings[$];
  int          errors;

  assign fail_count = errors;
  assign pending    = expected_readings.size();

  function automatic logic [63:0] shr_toward_zero(input logic [63:0] x, input int k);
    logic [63:0] mag;
    mag = -x;
    if (x[63]) begin
      return -(mag >> k);
    end
    return x >> k;
  endfunction

  function automatic logic [63:0] ext8(input logic [7:0] v);
    return {{56{v[7]}}, v};
  endfunction

  function automatic logic [63:0] ext16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic reading_t compensate(input logic [23:0] rp_in, input logic [23:0] rt_in);
    logic [63:0] rp, rt, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    logic [63:0] d, a, b, c, e, f, tlin, tc, sq, cube, offs, sens, sum, pcomp;
    reading_t r;
    rp = {40'd0, rp_in};
    rt = {40'd0, rt_in};
    t1 = {48'd0, temp_reg[15:0]};
    t2 = {48'd0, temp_reg[31:16]};
    t3 = ext8(temp_reg[39:32]);
    p1 = ext16(pa_reg[15:0]);
    p2 = ext16(pa_reg[31:16]);
    p3 = ext8(pa_reg[39:32]);
    p4 = ext8(pa_reg[47:40]);
    p5 = {48'd0, pb_reg[15:0]};
    p6 = {48'd0, pb_reg[31:16]};
    p7 = ext8(pb_reg[39:32]);
    p8 = ext8(pb_reg[47:40]);
    p9 = ext16(pc_reg[15:0]);
    p10 = ext8(pc_reg[23:16]);
    p11 = ext8(pc_reg[31:24]);

    d = rt - 64'd256 * t1;
    a = t2 * d;
    b = d * d;
    c = b * t3;
    e = a * 64'd262144 + c;
    tlin = shr_toward_zero(e, 32);
    tc = shr_toward_zero(tlin * 64'd25, 14);

    sq = tlin * tlin;
    cube = shr_toward_zero(shr_toward_zero(sq, 6) * tlin, 8);
    a = shr_toward_zero(p8 * cube, 5);
    b = (p7 * sq) * 64'd16;
    c = (p6 * tlin) * 64'd4194304;
    offs = p5 * 64'd140737488355328 + a + b + c;

    a = shr_toward_zero(p4 * cube, 5);
    b = (p3 * sq) * 64'd4;
    c = (p2 - 64'd16384) * tlin * 64'd2097152;
    sens = (p1 - 64'd16384) * 64'd70368744177664 + a + b + c;

    a = shr_toward_zero(sens, 24) * rp;
    b = p10 * tlin + 64'd65536 * p9;
    c = shr_toward_zero(b * rp, 13);
    e = shr_toward_zero(c * rp, 9);
    f = rp * rp;
    b = shr_toward_zero(p11 * f, 16);
    c = shr_toward_zero(b * rp, 7);
    sum = shr_toward_zero(offs, 2) + a + e + c;
    pcomp = (sum * 64'd25) >> 40;

    if (tc + 64'h8000_0000 < 64'h1_0000_0000) begin
      r.temp = tc[31:0];
    end else if (tc[63]) begin
      r.temp = 32'h8000_0000;
    end else begin
      r.temp = 32'h7FFF_FFFF;
    end
    r.press = (pcomp > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : pcomp[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t got;
    if (rst) begin
      temp_reg <= '0;
      pa_reg   <= '0;
      pb_reg   <= '0;
      pc_reg   <= '0;
      expected_readings.delete();
      errors = 0;
    end else begin
      if (done) begin
        if (expected_readings.size() == 0) begin
          $error("result beat with no expected reading: temp %0d press %0d",
                 temperature_centi, pressure_centi_pa);
          errors++;
        end else begin
          got = expected_readings.pop_front();
          if (temperature_centi !== got.temp) begin
            $error("temperature_centi: expected %0d, actual %0d", got.temp, temperature_centi);
            errors++;
          end
          if (pressure_centi_pa !== got.press) begin
            $error("pressure_centi_pa: expected %0d, actual %0d", got.press, pressure_centi_pa);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        expected_readings.push_back(compensate(raw_pressure, raw_temperature));
      end
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_TEMP: temp_reg <= cfg_data[39:0];
          REG_PA:   pa_reg   <= cfg_data;
          REG_PB:   pb_reg   <= cfg_data;
          REG_PC:   pc_reg   <= cfg_data[31:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import bsc_pkg::*;

  localparam int Latency = 18;
  localparam int StallLimit = 5000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [23:0]         raw_pressure = '0;
  logic [23:0]         raw_temperature = '0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                done;
  logic signed [31:0]  temperature_centi;
  logic [31:0]         pressure_centi_pa;
  int                  fail_count;
  int                  pending;
  int                  quiet_cycles = 0;
  int                  burst_left = 0;
  logic [23:0]         temp_center;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  barometric_sensor_compensation dut (.*);

  barometric_checker checker_i (.*);

  always @(posedge clk) begin
    if (rst || done || (start && !busy) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_reading(input logic [23:0] rp, input logic [23:0] rt);
    start <= 1'b1;
    raw_pressure <= rp;
    raw_temperature <= rt;
    do @(posedge clk); while (busy);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Latency + 2) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CfgDataW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic load_all(input logic [47:0] t, input logic [47:0] a,
                          input logic [47:0] b, input logic [47:0] c);
    write_reg(REG_TEMP, t);
    write_reg(REG_PA, a);
    write_reg(REG_PB, b);
    write_reg(REG_PC, c);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_plausible();
    logic [15:0] t1;
    t1 = 16'($urandom_range(26000, 29000));
    temp_center = {t1, 8'd0};
    load_all({8'd0, 8'($urandom_range(0, 15) - 8), 16'($urandom_range(18000, 20000)), t1},
             {8'($urandom), 8'($urandom), 16'($urandom_range(0, 1000) - 500),
              16'($urandom_range(0, 1000) - 500)},
             {8'($urandom), 8'($urandom), 16'($urandom_range(25000, 35000)),
              16'($urandom_range(20000, 30000))},
             {16'd0, 8'($urandom), 8'($urandom), 16'($urandom)});
  endtask

  task automatic directed_corners();
    logic [23:0] corner[4];
    corner = '{24'h000000, 24'hFFFFFF, 24'h800000, 24'h7FFFFF};
    foreach (corner[i]) begin
      foreach (corner[j]) begin
        send_reading(corner[i], corner[j]);
      end
    end
  endtask

  task automatic random_phase(input int count, input bit plausible);
    logic [23:0] rt;
    repeat (count) begin
      if (plausible && $urandom_range(0, 9) < 7) begin
        rt = temp_center + 24'($urandom_range(0, 200000)) - 24'd100000;
        send_reading(24'($urandom_range(5000000, 9000000)), rt);
      end else begin
        send_reading(24'($urandom), 24'($urandom));
      end
    end
  endtask

  initial begin
    temp_center = 24'h700000;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_corners();
    drain();

    load_all('1, '1, '1, '1);
    directed_corners();
    drain();

    load_all('0, '0, '0, '0);
    random_phase(40, 1'b0);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      if (phase % 2 == 0) begin
        load_plausible();
        random_phase(250, 1'b1);
      end else begin
        load_all(rand48(), rand48(), rand48(), rand48());
        random_phase(150, 1'b0);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
